[src/lrupr_pkg.sv]
// Shared types and constants for the LRU page replacement block.
// Used by the frame cell, the sequencer and the top level; no dependencies.
`default_nettype none

package lrupr_pkg;

  localparam int unsigned FRAMES_DEF    = 8;
  localparam int unsigned PAGE_BITS_DEF = 8;

  localparam int unsigned PAGE_W     = 8;
  localparam int unsigned FIDX_W     = 3;
  localparam int unsigned FIU_W      = 4;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned RANK_W     = 8;
  localparam int unsigned IDX_MAX_W  = 6;
  localparam int unsigned PAGE_MAX_W = 32;

  localparam logic [FIU_W-1:0] FIU_RESET = 4'd8;

  localparam logic KIND_REF     = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_e;

  typedef struct packed {
    logic                  found;
    logic [IDX_MAX_W-1:0]  found_idx;
    logic [RANK_W-1:0]     found_rank;
    logic                  free;
    logic [IDX_MAX_W-1:0]  free_idx;
    logic [RANK_W-1:0]     max_rank;
    logic [IDX_MAX_W-1:0]  max_idx;
    logic [PAGE_MAX_W-1:0] max_page;
  } token_t;

  typedef struct packed {
    logic                 strobe;
    logic                 restart;
    logic                 hit;
    logic [IDX_MAX_W-1:0] slot;
    logic [RANK_W-1:0]    hit_rank;
  } upd_t;

endpackage

`default_nettype wire

[src/lru_page_replacement.sv]
// LRU page replacement, top level: configuration register, chain of frame cells, sequencer.
// Depends on lrupr_pkg, lrupr_cell and lrupr_ctrl.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries kind_i and page_number_i; a transaction
//   is taken when valid is high and stall low. Output channel (out_valid_o / out_stall_i)
//   returns one result per input transaction, in order.
//   A page reference scans the chain of FRAMES cells, one cell per cycle, then commits the
//   update to every cell at once and registers the result. A new reference is taken only
//   after the last one has committed; a restart skips the scan and goes to the commit.
//   The result register parts the two sides: the next input is taken while a result waits.
//   When the receiver stalls, the result holds; a finished item waits in its commit cycle
//   until the result register is free, and input stays stalled meanwhile.
//   frames_in_use is written through cfg_valid_i / cfg_ready_o (always ready), by the user
//   only while idle, not enforced by the block; 0 acts as 1, values above FRAMES as FRAMES.
//   Reset: all frames free, ranks and fault count zero, frames_in_use 8, no result pending.
`default_nettype none

module lru_page_replacement
  import lrupr_pkg::*;
#(
  parameter int unsigned FRAMES    = FRAMES_DEF,
  parameter int unsigned PAGE_BITS = PAGE_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [FIU_W-1:0]   cfg_frames_in_use_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               kind_i,
  input  wire logic [PAGE_W-1:0]  page_number_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    hit_o,
  output logic [FIDX_W-1:0]       frame_index_o,
  output logic                    evicted_valid_o,
  output logic [PAGE_W-1:0]       evicted_page_o,
  output logic [COUNT_W-1:0]      fault_count_o
);

  logic [FIU_W-1:0]     fiu_q;
  logic [PAGE_BITS-1:0] key;
  upd_t                 upd;
  token_t               tok [FRAMES+1];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fiu_q <= FIU_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      fiu_q <= cfg_frames_in_use_i;
    end
  end

  assign tok[0] = '0;

  for (genvar g = 0; g < FRAMES; g++) begin : g_cell
    lrupr_cell #(
      .IDX       (g),
      .PAGE_BITS (PAGE_BITS)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cfg_fiu_i (fiu_q),
      .key_i     (key),
      .upd_i     (upd),
      .tok_i     (tok[g]),
      .tok_o     (tok[g+1])
    );
  end

  lrupr_ctrl #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .kind_i          (kind_i),
    .page_number_i   (page_number_i),
    .key_o           (key),
    .upd_o           (upd),
    .tok_i           (tok[FRAMES]),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .hit_o           (hit_o),
    .frame_index_o   (frame_index_o),
    .evicted_valid_o (evicted_valid_o),
    .evicted_page_o  (evicted_page_o),
    .fault_count_o   (fault_count_o)
  );

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> !evicted_valid_o)
    else $error("eviction reported on a hit");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second transaction taken while busy");

  a_evict_page_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !evicted_valid_o |-> evicted_page_o == '0)
    else $error("evicted page set without eviction");

  a_hit_needs_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> fault_count_o != '0)
    else $error("hit reported with no prior fault");

endmodule

`default_nettype wire

[src/lrupr_cell.sv]
// One frame of the LRU chain: resident page, valid bit and recency rank.
// Folds its frame into the search token passed along the chain; uses lrupr_pkg.
`default_nettype none

module lrupr_cell
  import lrupr_pkg::*;
#(
  parameter int unsigned IDX       = 0,
  parameter int unsigned PAGE_BITS = PAGE_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [FIU_W-1:0]     cfg_fiu_i,
  input  wire logic [PAGE_BITS-1:0] key_i,
  input  wire upd_t                 upd_i,
  input  wire token_t               tok_i,
  output token_t                    tok_o
);

  logic [PAGE_BITS-1:0] page_q, page_d;
  logic                 valid_q, valid_d;
  logic [RANK_W-1:0]    rank_q, rank_d;
  logic [RANK_W-1:0]    rank_inc;
  token_t               tok_q, tok_d;
  logic                 active;
  logic [IDX_MAX_W-1:0] my_idx;

  assign my_idx   = IDX_MAX_W'(IDX);
  assign active   = (IDX == 0) || (32'(cfg_fiu_i) > 32'(IDX));
  assign rank_inc = (rank_q == '1) ? rank_q : rank_q + 1'b1;

  always_comb begin
    tok_d = tok_i;
    if (active) begin
      if (!tok_i.found && valid_q && (page_q == key_i)) begin
        tok_d.found      = 1'b1;
        tok_d.found_idx  = my_idx;
        tok_d.found_rank = rank_q;
      end
      if (!tok_i.free && !valid_q) begin
        tok_d.free     = 1'b1;
        tok_d.free_idx = my_idx;
      end
      if ((IDX == 0) || (rank_q > tok_i.max_rank)) begin
        tok_d.max_rank = rank_q;
        tok_d.max_idx  = my_idx;
        tok_d.max_page = PAGE_MAX_W'(page_q);
      end
    end
  end

  always_comb begin
    page_d  = page_q;
    valid_d = valid_q;
    rank_d  = rank_q;
    if (upd_i.strobe) begin
      if (upd_i.restart) begin
        valid_d = 1'b0;
        rank_d  = '0;
      end else if (upd_i.hit) begin
        if (upd_i.slot == my_idx) begin
          rank_d = '0;
        end else if (active && valid_q && (rank_q < upd_i.hit_rank)) begin
          rank_d = rank_inc;
        end
      end else begin
        if (upd_i.slot == my_idx) begin
          page_d  = key_i;
          valid_d = 1'b1;
          rank_d  = '0;
        end else if (active && valid_q) begin
          rank_d = rank_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rank_q  <= '0;
    end else begin
      valid_q <= valid_d;
      rank_q  <= rank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q <= page_d;
    tok_q  <= tok_d;
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

[src/lrupr_ctrl.sv]
// Sequencer for the LRU chain: input transaction, scan timing, commit and result register.
// Holds the fault count; uses lrupr_pkg.
`default_nettype none

module lrupr_ctrl
  import lrupr_pkg::*;
#(
  parameter int unsigned FRAMES    = FRAMES_DEF,
  parameter int unsigned PAGE_BITS = PAGE_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic                 kind_i,
  input  wire logic [PAGE_W-1:0]    page_number_i,
  output logic [PAGE_BITS-1:0]      key_o,
  output upd_t                      upd_o,
  input  wire token_t               tok_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic                      hit_o,
  output logic [FIDX_W-1:0]         frame_index_o,
  output logic                      evicted_valid_o,
  output logic [PAGE_W-1:0]         evicted_page_o,
  output logic [COUNT_W-1:0]        fault_count_o
);

  localparam int unsigned CNT_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned KX_W   = (PAGE_BITS > PAGE_W) ? PAGE_BITS : PAGE_W;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAMES - 1);

  state_e               state_q, state_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 kind_q;
  logic [PAGE_BITS-1:0] key_q;
  logic [KX_W-1:0]      page_x;
  logic [COUNT_W-1:0]   fault_q, fault_d;
  logic                 accept, load;

  logic                 hit;
  logic [IDX_MAX_W-1:0] slot;
  logic                 ev;

  logic                 out_valid_q;
  logic                 hit_q;
  logic [FIDX_W-1:0]    fidx_q;
  logic                 ev_q;
  logic [PAGE_W-1:0]    ev_page_q;

  assign page_x = KX_W'(page_number_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (kind_i == KIND_RESTART) ? ST_COMMIT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt_q == CNT_LAST) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    accept     = in_valid_i && (state_q == ST_IDLE);
    load       = (state_q == ST_COMMIT) && (!out_valid_q || !out_stall_i);
    cnt_d      = (state_q == ST_SCAN) ? cnt_q + 1'b1 : '0;
  end

  always_comb begin
    hit  = tok_i.found;
    ev   = !tok_i.found && !tok_i.free;
    if (tok_i.found) begin
      slot = tok_i.found_idx;
    end else if (tok_i.free) begin
      slot = tok_i.free_idx;
    end else begin
      slot = tok_i.max_idx;
    end
    upd_o.strobe   = load;
    upd_o.restart  = (kind_q == KIND_RESTART);
    upd_o.hit      = hit;
    upd_o.slot     = slot;
    upd_o.hit_rank = tok_i.found_rank;
  end

  always_comb begin
    fault_d = fault_q;
    if (load) begin
      if (kind_q == KIND_RESTART) begin
        fault_d = '0;
      end else if (!hit && (fault_q != '1)) begin
        fault_d = fault_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      fault_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      fault_q <= fault_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_i;
      key_q  <= page_x[PAGE_BITS-1:0];
    end
    if (load) begin
      if (kind_q == KIND_RESTART) begin
        hit_q     <= 1'b0;
        fidx_q    <= '0;
        ev_q      <= 1'b0;
        ev_page_q <= '0;
      end else begin
        hit_q     <= hit;
        fidx_q    <= slot[FIDX_W-1:0];
        ev_q      <= ev;
        ev_page_q <= ev ? tok_i.max_page[PAGE_W-1:0] : '0;
      end
    end
  end

  assign key_o           = key_q;
  assign out_valid_o     = out_valid_q;
  assign hit_o           = hit_q;
  assign frame_index_o   = fidx_q;
  assign evicted_valid_o = ev_q;
  assign evicted_page_o  = ev_page_q;
  assign fault_count_o   = fault_q;

endmodule

`default_nettype wire

[dv/lrupr_checker.sv]
`timescale 1ns / 1ps
// Checker for the LRU page replacement block: watches the configuration, input and
// result channels, predicts each result and compares it. Depends on lrupr_pkg.
module lrupr_checker
  import lrupr_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  input  wire logic               cfg_ready_i,
  input  wire logic [FIU_W-1:0]   cfg_frames_in_use_i,
  input  wire logic               in_valid_i,
  input  wire logic               in_stall_i,
  input  wire logic               kind_i,
  input  wire logic [PAGE_W-1:0]  page_number_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_stall_i,
  input  wire logic               hit_i,
  input  wire logic [FIDX_W-1:0]  frame_index_i,
  input  wire logic               evicted_valid_i,
  input  wire logic [PAGE_W-1:0]  evicted_page_i,
  input  wire logic [COUNT_W-1:0] fault_count_i,
  output int                      mismatches_o,
  output int                      pending_o
);

  localparam int FRAMES       = FRAMES_DEF;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic                 hit;
    logic [FIDX_W-1:0]    frame_index;
    logic                 evicted_valid;
    logic [PAGE_W-1:0]    evicted_page;
    logic [COUNT_W-1:0]   fault_count;
  } page_outcome_t;

  logic [FIU_W-1:0]   frames_reg;
  logic [PAGE_W-1:0]  held_page  [FRAMES];
  logic               held_valid [FRAMES];
  logic [RANK_W-1:0]  held_rank  [FRAMES];
  logic [COUNT_W-1:0] fault_total;
  page_outcome_t      outcome_q [$];
  int                 mismatch_total;

  function automatic page_outcome_t take_reference(input logic k, input logic [PAGE_W-1:0] pg);
    page_outcome_t     res;
    int                n;
    int                i;
    int                slot;
    logic              found;
    logic [RANK_W-1:0] hit_rank;
    res   = '0;
    slot  = 0;
    found = 1'b0;
    if (frames_reg == 0) n = 1;
    else if (frames_reg > FRAMES) n = FRAMES;
    else n = int'(frames_reg);

    if (k == KIND_RESTART) begin
      for (i = 0; i < FRAMES; i++) begin
        held_valid[i] = 1'b0;
        held_rank[i]  = '0;
      end
      fault_total = '0;
      return res;
    end

    for (i = 0; i < n; i++) begin
      if (!found && held_valid[i] && held_page[i] == pg) begin
        slot  = i;
        found = 1'b1;
      end
    end

    if (found) begin
      res.hit  = 1'b1;
      hit_rank = held_rank[slot];
      for (i = 0; i < n; i++) begin
        if (held_valid[i] && held_rank[i] < hit_rank && held_rank[i] != '1)
          held_rank[i] = held_rank[i] + 1'b1;
      end
      held_rank[slot] = '0;
    end else begin
      if (fault_total != '1) fault_total = fault_total + 1'b1;
      for (i = 0; i < n; i++) begin
        if (!found && !held_valid[i]) begin
          slot  = i;
          found = 1'b1;
        end
      end
      if (!found) begin
        slot = 0;
        for (i = 1; i < n; i++) begin
          if (held_rank[i] > held_rank[slot]) slot = i;
        end
        res.evicted_valid = 1'b1;
        res.evicted_page  = held_page[slot];
        held_valid[slot]  = 1'b0;
      end
      for (i = 0; i < n; i++) begin
        if (held_valid[i] && held_rank[i] != '1) held_rank[i] = held_rank[i] + 1'b1;
      end
      held_page[slot]  = pg;
      held_valid[slot] = 1'b1;
      held_rank[slot]  = '0;
    end

    res.frame_index = slot[FIDX_W-1:0];
    res.fault_count = fault_total;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    page_outcome_t want;
    page_outcome_t got;
    int            i;
    if (!rst_ni) begin
      frames_reg  = FIU_RESET;
      fault_total = '0;
      for (i = 0; i < FRAMES; i++) begin
        held_page[i]  = '0;
        held_valid[i] = 1'b0;
        held_rank[i]  = '0;
      end
      outcome_q.delete();
      mismatch_total = 0;
      mismatches_o  <= 0;
      pending_o     <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) frames_reg = cfg_frames_in_use_i;

      if (out_valid_i && !out_stall_i) begin
        got = {hit_i, frame_index_i, evicted_valid_i, evicted_page_i, fault_count_i};
        if (outcome_q.size() == 0) begin
          mismatch_total++;
          if (mismatch_total <= REPORT_LIMIT)
            $display("%0t: result transaction with none outstanding: hit=%0b frame=%0d",
                     $time, got.hit, got.frame_index);
        end else begin
          want = outcome_q.pop_front();
          if (got.hit != want.hit || got.frame_index != want.frame_index ||
              got.evicted_valid != want.evicted_valid ||
              got.evicted_page != want.evicted_page ||
              got.fault_count != want.fault_count) begin
            mismatch_total++;
            if (mismatch_total <= REPORT_LIMIT)
              $display({"%0t: result mismatch: expected hit=%0b frame=%0d evicted=%0b/%0d ",
                        "faults=%0d, actual hit=%0b frame=%0d evicted=%0b/%0d faults=%0d"},
                       $time, want.hit, want.frame_index, want.evicted_valid,
                       want.evicted_page, want.fault_count, got.hit, got.frame_index,
                       got.evicted_valid, got.evicted_page, got.fault_count);
          end
        end
      end

      if (in_valid_i && !in_stall_i) outcome_q.push_back(take_reference(kind_i, page_number_i));

      mismatches_o <= mismatch_total;
      pending_o    <= outcome_q.size();
    end
  end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// Testbench top for the LRU page replacement block: clock, reset, stimulus phases
// and verdict. Depends on lrupr_pkg, lru_page_replacement and lrupr_checker.
module tb_top;
  import lrupr_pkg::*;

  localparam int              SETTLE_CYCLES = FRAMES_DEF + 6;
  localparam longint unsigned CYCLE_LIMIT   = 200_000;
  localparam int              PHASE_ITEMS   = 420;
  localparam int              SAT_ITEMS     = 24;

  logic                 clk         = 1'b0;
  logic                 rst_n       = 1'b0;
  logic                 cfg_valid   = 1'b0;
  logic                 cfg_ready;
  logic [FIU_W-1:0]     cfg_frames  = FIU_RESET;
  logic                 in_valid    = 1'b0;
  logic                 in_stall;
  logic                 kind        = KIND_REF;
  logic [PAGE_W-1:0]    page        = '0;
  logic                 out_valid;
  logic                 out_stall   = 1'b0;
  logic                 hit;
  logic [FIDX_W-1:0]    frame_index;
  logic                 evicted_valid;
  logic [PAGE_W-1:0]    evicted_page;
  logic [COUNT_W-1:0]   fault_count;
  int                   mismatches;
  int                   pending;
  int                   idle_pct    = 0;
  int                   stall_pct   = 0;
  logic [PAGE_W-1:0]    page_base   = '0;
  longint unsigned      cycles      = 0;

  lru_page_replacement dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_o         (cfg_ready),
    .cfg_frames_in_use_i (cfg_frames),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .kind_i              (kind),
    .page_number_i       (page),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .hit_o               (hit),
    .frame_index_o       (frame_index),
    .evicted_valid_o     (evicted_valid),
    .evicted_page_o      (evicted_page),
    .fault_count_o       (fault_count)
  );

  lrupr_checker u_checker (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_i         (cfg_ready),
    .cfg_frames_in_use_i (cfg_frames),
    .in_valid_i          (in_valid),
    .in_stall_i          (in_stall),
    .kind_i              (kind),
    .page_number_i       (page),
    .out_valid_i         (out_valid),
    .out_stall_i         (out_stall),
    .hit_i               (hit),
    .frame_index_i       (frame_index),
    .evicted_valid_i     (evicted_valid),
    .evicted_page_i      (evicted_page),
    .fault_count_i       (fault_count),
    .mismatches_o        (mismatches),
    .pending_o           (pending)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic drive_txn(input logic k, input logic [PAGE_W-1:0] pg);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    page     <= pg;
    do @(posedge clk); while (in_stall);
  endtask

  // hold input idle until every outstanding result has come back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_frames(input logic [FIU_W-1:0] v);
    @(negedge clk);
    cfg_valid  <= 1'b1;
    cfg_frames <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_items(input int count);
    int                i;
    int                r;
    logic [PAGE_W-1:0] pg;
    logic [PAGE_W-1:0] off;
    for (i = 0; i < count; i++) begin
      if ($urandom_range(49) == 0) page_base = PAGE_W'($urandom_range(255));
      r   = int'($urandom_range(99));
      pg  = PAGE_W'($urandom_range(255));
      off = PAGE_W'($urandom_range(FRAMES_DEF + 2));
      if (r < 3) drive_txn(KIND_RESTART, pg);
      else if (r < 15) drive_txn(KIND_REF, pg);
      else drive_txn(KIND_REF, page_base + off);
    end
  endtask

  initial begin
    int i;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_frames(4'd3);
    drive_txn(KIND_RESTART, 8'hA5);
    drive_txn(KIND_REF, 8'd0);
    drive_txn(KIND_REF, 8'd255);
    drive_txn(KIND_REF, 8'd0);
    drive_txn(KIND_REF, 8'd170);
    drive_txn(KIND_REF, 8'd85);
    drive_txn(KIND_REF, 8'd0);
    drive_txn(KIND_REF, 8'd255);
    drive_txn(KIND_REF, 8'd1);
    drive_txn(KIND_REF, 8'd128);
    drive_txn(KIND_REF, 8'd127);
    drive_txn(KIND_RESTART, 8'hFF);
    drive_txn(KIND_REF, 8'd255);
    drive_txn(KIND_REF, 8'd255);
    drain();

    // widen without restart: frames beyond the old count come back empty
    write_frames(4'd15);
    idle_pct  = 0;
    stall_pct = 0;
    random_items(PHASE_ITEMS);
    drain();

    write_frames(4'd0);
    idle_pct = 53;
    random_items(PHASE_ITEMS / 2);
    drain();
    random_items(PHASE_ITEMS / 2);
    drain();

    write_frames(4'd8);
    idle_pct  = 0;
    stall_pct = 53;
    random_items(PHASE_ITEMS);
    drain();

    write_frames(FIU_W'($urandom_range(15)));
    idle_pct  = 17;
    stall_pct = 17;
    random_items(PHASE_ITEMS);
    drain();

    // one frame and changing pages: every reference faults, every one after the first evicts
    write_frames(4'd1);
    idle_pct  = 0;
    stall_pct = 0;
    drive_txn(KIND_RESTART, 8'h00);
    for (i = 0; i < SAT_ITEMS; i++) drive_txn(KIND_REF, i[PAGE_W-1:0]);
    drain();

    if (mismatches == 0 && pending == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

[sim.f]
src/lrupr_pkg.sv
src/lrupr_cell.sv
src/lrupr_ctrl.sv
src/lru_page_replacement.sv
dv/lrupr_checker.sv
dv/tb_top.sv
